[rtl/mavg_pkg.sv]
// Package for the moving average filter: shared constants and the
// back-end state type. No dependencies.
`default_nettype none

package mavg_pkg;

  localparam int DEF_MAX_WINDOW  = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int CFG_W      = 11;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;
  localparam int REG_IDX_W  = ADDR_W - 2;

  localparam logic [CFG_W-1:0]     WINDOW_LENGTH_RESET = CFG_W'(8);
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH   = '0;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ADD,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } back_state_t;

endpackage

`default_nettype wire

[rtl/mavg_if.sv]
// Item channel interfaces for the moving average filter.
// Depends on mavg_pkg.
`default_nettype none

interface mavg_in_if #(
  parameter int SAMPLE_BITS = mavg_pkg::DEF_SAMPLE_BITS
);
  import mavg_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          start_of_block;

  modport source (output valid, output sample, output start_of_block, input ready);
  modport sink   (input valid, input sample, input start_of_block, output ready);
endinterface

interface mavg_out_if #(
  parameter int SAMPLE_BITS = mavg_pkg::DEF_SAMPLE_BITS
);
  import mavg_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

`default_nettype wire

[rtl/mavg_front.sv]
// Front end: accepts input items and marks those that seed the window.
// Depends on mavg_pkg and mavg_in_if.
`default_nettype none

module mavg_front #(
  parameter int SAMPLE_BITS = mavg_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  mavg_in_if.sink                     samples,
  input  wire logic                   cfg_write,
  output logic                        push,
  output logic [SAMPLE_BITS:0]        push_data,
  input  wire logic                   full
);
  import mavg_pkg::*;

  logic primed;
  logic seed;

  assign samples.ready = !full;
  assign push          = samples.valid && !full;
  assign seed          = !primed || samples.start_of_block;
  assign push_data     = {seed, samples.sample};

  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
    end else if (cfg_write) begin
      primed <= 1'b0;
    end else if (push) begin
      primed <= 1'b1;
    end
  end

endmodule

`default_nettype wire

[rtl/mavg_fifo.sv]
// Short queue between the front end and the back end.
// Depends on mavg_pkg.
`default_nettype none

module mavg_fifo #(
  parameter int W = mavg_pkg::DEF_SAMPLE_BITS + 1
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              empty
);
  import mavg_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/mavg_back.sv]
// Back end: sample store, running window sum, serial divider, output register.
// Depends on mavg_pkg and mavg_out_if.
`default_nettype none

module mavg_back #(
  parameter int MAX_WINDOW  = mavg_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = mavg_pkg::DEF_SAMPLE_BITS,
  parameter int LEN_W       = $clog2(MAX_WINDOW + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [LEN_W-1:0]       n_len,
  input  wire logic [SAMPLE_BITS:0]   pop_data,
  input  wire logic                   empty,
  output logic                        pop,
  mavg_out_if.source                  averages
);
  import mavg_pkg::*;

  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int SUM_W = SAMPLE_BITS + LEN_W;
  localparam int CNT_W = $clog2(SUM_W);
  localparam int AW    = LEN_W + 1;

  back_state_t state;
  back_state_t state_next;

  logic [SAMPLE_BITS-1:0]        store [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] rdata;
  logic signed [SAMPLE_BITS-1:0] cur_sample;
  logic                          cur_seed;
  logic signed [SAMPLE_BITS-1:0] seed_sample;
  logic [PTR_W-1:0]              wr_ptr;
  logic [LEN_W-1:0]              fill;
  logic signed [SUM_W-1:0]       window_sum;

  logic [SUM_W-1:0]              dvd;
  logic [LEN_W-1:0]              rem;
  logic                          neg;
  logic [CNT_W-1:0]              cnt;

  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_average;
  logic                          out_load;

  logic [AW-1:0]                 addr_sum;
  logic [PTR_W-1:0]              rd_addr;
  logic signed [SUM_W-1:0]       n_ext;
  logic signed [SUM_W-1:0]       x_ext;
  logic signed [SUM_W-1:0]       seed_sum;
  logic signed [SAMPLE_BITS-1:0] leaving;
  logic signed [SUM_W-1:0]       sum_new;
  logic [LEN_W:0]                rem_sh;
  logic                          ge;
  logic [SUM_W-1:0]              quo;

  assign averages.valid   = out_valid;
  assign averages.average = out_average;

  assign addr_sum = AW'(wr_ptr) + AW'(MAX_WINDOW) - AW'(n_len);
  assign rd_addr  = (addr_sum >= AW'(MAX_WINDOW)) ? PTR_W'(addr_sum - AW'(MAX_WINDOW))
                                                  : PTR_W'(addr_sum);
  assign n_ext    = SUM_W'(n_len);
  assign x_ext    = SUM_W'(cur_sample);
  assign seed_sum = n_ext * x_ext;
  assign leaving  = (fill >= n_len) ? rdata : seed_sample;
  assign sum_new  = window_sum + x_ext - SUM_W'(leaving);
  assign rem_sh   = {rem, dvd[SUM_W-1]};
  assign ge       = (rem_sh >= {1'b0, n_len});
  assign quo      = neg ? (~dvd + 1'b1) : dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_ADD;
      ST_ADD:  state_next = ST_LOAD;
      ST_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == '0) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || averages.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      rdata <= store[rd_addr];
    end
    if (state == ST_ADD) begin
      store[wr_ptr] <= cur_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_seed   <= pop_data[SAMPLE_BITS];
      cur_sample <= pop_data[SAMPLE_BITS-1:0];
    end
    if (state == ST_READ && cur_seed) begin
      seed_sample <= cur_sample;
    end
    if (state == ST_LOAD) begin
      neg <= window_sum[SUM_W-1];
      dvd <= window_sum[SUM_W-1] ? SUM_W'(-window_sum) : SUM_W'(window_sum);
      rem <= '0;
      cnt <= CNT_W'(SUM_W - 1);
    end else if (state == ST_DIV) begin
      rem <= ge ? LEN_W'(rem_sh - {1'b0, n_len}) : LEN_W'(rem_sh);
      dvd <= {dvd[SUM_W-2:0], ge};
      cnt <= cnt - 1'b1;
    end
    if (out_load) begin
      out_average <= SAMPLE_BITS'(quo);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      fill       <= '0;
      window_sum <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (state == ST_READ && cur_seed) begin
        wr_ptr     <= '0;
        fill       <= '0;
        window_sum <= seed_sum;
      end
      if (state == ST_ADD) begin
        window_sum <= sum_new;
        wr_ptr     <= (wr_ptr == PTR_W'(MAX_WINDOW - 1)) ? '0 : wr_ptr + 1'b1;
        if (fill != LEN_W'(MAX_WINDOW)) begin
          fill <= fill + 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (averages.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_rem_below_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < n_len))
    else $error("divider remainder not below window length");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= LEN_W'(MAX_WINDOW))
    else $error("fill count above window capacity");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    AW'(wr_ptr) < AW'(MAX_WINDOW))
    else $error("write pointer beyond store");

  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !out_valid) |=> (out_valid && state == ST_IDLE))
    else $error("finished item not loaded into output register");
`endif

endmodule

`default_nettype wire

[rtl/moving_average_filter_core.sv]
// Top level of the boxcar moving average filter: register port, front end,
// queue and back end. Depends on mavg_pkg, mavg_if, mavg_front, mavg_fifo, mavg_back.
//
//   channel    dir   handshake          payload
//   samples    in    valid/ready        sample, start_of_block
//   averages   out   valid/ready        average
//   apb        in    psel/penable       paddr, pwdata, pwrite -> prdata, pready
//
// The back end reads, adds and loads each item, then runs the one-bit-per-cycle
// restoring divider; it takes the next item only after its output register is loaded.
// The front end and a two-entry queue keep taking items while the back end works.
// Reset is synchronous; the sample store needs no clearing pass.
// A stalled output holds the back end in its output state; the queue fills, then
// samples.ready drops.
`default_nettype none

module moving_average_filter_core #(
  parameter int MAX_WINDOW  = mavg_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = mavg_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  mavg_in_if.sink                            samples,
  mavg_out_if.source                         averages,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mavg_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [mavg_pkg::DATA_W-1:0]   pwdata,
  output logic [mavg_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);
  import mavg_pkg::*;

  localparam int LEN_W = $clog2(MAX_WINDOW + 1);

  logic [CFG_W-1:0]       window_length;
  logic [REG_IDX_W-1:0]   reg_idx;
  logic                   cfg_write;
  logic [LEN_W-1:0]       n_len;

  logic                   push;
  logic [SAMPLE_BITS:0]   push_data;
  logic                   full;
  logic                   pop;
  logic [SAMPLE_BITS:0]   pop_data;
  logic                   empty;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && (reg_idx == REG_WINDOW_LENGTH);
  assign prdata    = (reg_idx == REG_WINDOW_LENGTH) ? DATA_W'(window_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RESET;
    end else if (cfg_write) begin
      window_length <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    priority if (window_length == '0) begin
      n_len = LEN_W'(1);
    end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
      n_len = LEN_W'(MAX_WINDOW);
    end else begin
      n_len = LEN_W'(window_length);
    end
  end

  mavg_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .cfg_write (cfg_write),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  mavg_fifo #(
    .W (SAMPLE_BITS + 1)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  mavg_back #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .LEN_W       (LEN_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .n_len    (n_len),
    .pop_data (pop_data),
    .empty    (empty),
    .pop      (pop),
    .averages (averages)
  );

endmodule

`default_nettype wire

[bench/moving_average_filter_core_test.sv]
// Self-checking bench for moving_average_filter_core: directed and random samples,
// random handshake idling, window_length writes and read-backs over APB.
// Depends on mavg_pkg, mavg_in_if, mavg_out_if and the RTL of the filter.

module moving_average_filter_core_test;
  import mavg_pkg::*;

  localparam int MAX_WIN = DEF_MAX_WINDOW;
  localparam int SBITS   = DEF_SAMPLE_BITS;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = REG_IDX_W'(1);

  typedef logic signed [SBITS-1:0] sample_t;

  class average_scoreboard;
    sample_t          delay_line [MAX_WIN];
    int unsigned      wr_ptr = 0;
    int unsigned      filled = 0;
    sample_t          seed = '0;
    longint           running_sum = 0;
    bit               primed = 1'b0;
    logic [CFG_W-1:0] window_length = WINDOW_LENGTH_RESET;
    sample_t          pending_averages[$];
    int               errors = 0;
    int               samples_seen = 0;
    int               averages_seen = 0;
    int               restarts = 0;

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      if (idx == REG_WINDOW_LENGTH) begin
        window_length = data[CFG_W-1:0];
        primed = 1'b0;
      end
    endfunction

    function int unsigned window_span();
      if (window_length == 0) return 1;
      if (window_length > MAX_WIN) return MAX_WIN;
      return window_length;
    endfunction

    function void note_sample(sample_t x, logic sob);
      int unsigned n;
      sample_t     leaving;
      longint      quotient;
      n = window_span();
      samples_seen++;
      if (!primed || sob) begin
        primed = 1'b1;
        seed = x;
        wr_ptr = 0;
        filled = 0;
        running_sum = longint'(n) * longint'(x);
        restarts++;
      end
      if (filled >= n) leaving = delay_line[(wr_ptr + MAX_WIN - n) % MAX_WIN];
      else leaving = seed;
      delay_line[wr_ptr] = x;
      wr_ptr = (wr_ptr + 1) % MAX_WIN;
      if (filled < MAX_WIN) filled++;
      running_sum += longint'(x) - longint'(leaving);
      quotient = running_sum / longint'(n);
      pending_averages.push_back(quotient[SBITS-1:0]);
    endfunction

    function void check_average(sample_t got);
      sample_t want;
      averages_seen++;
      if (pending_averages.size() == 0) begin
        $error("average: expected nothing, got %0d", got);
        errors++;
      end else begin
        want = pending_averages.pop_front();
        if (got !== want) begin
          $error("average: expected %0d, got %0d", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  mavg_in_if  #(.SAMPLE_BITS(SBITS)) samples_if ();
  mavg_out_if #(.SAMPLE_BITS(SBITS)) averages_if ();

  average_scoreboard board = new();

  bit quiet = 1'b0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_left = 0;
  int reg_errors = 0;
  int settings_used = 0;

  moving_average_filter_core #(
    .MAX_WINDOW(MAX_WIN),
    .SAMPLE_BITS(SBITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .samples(samples_if),
    .averages(averages_if),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    samples_if.valid = 1'b0;
    samples_if.sample = '0;
    samples_if.start_of_block = 1'b0;
    averages_if.ready = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && averages_if.valid && averages_if.ready) board.check_average(averages_if.average);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      averages_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(99) < recv_idle_pct) begin
      stall_left <= $urandom_range(3);
      averages_if.ready <= 1'b0;
    end else begin
      averages_if.ready <= 1'b1;
    end
  end

  task automatic send_sample(sample_t x, logic sob);
    if (!quiet && $urandom_range(99) < send_idle_pct) begin
      samples_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    samples_if.valid <= 1'b1;
    samples_if.sample <= x;
    samples_if.start_of_block <= sob;
    do @(posedge clk); while (!samples_if.ready);
    board.note_sample(x, sob);
  endtask

  task automatic drain();
    samples_if.valid <= 1'b0;
    do @(posedge clk); while (board.pending_averages.size() != 0);
  endtask

  task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.write_reg(idx, data);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_window_length();
    logic [DATA_W-1:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_W'({REG_WINDOW_LENGTH, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== DATA_W'(board.window_length)) begin
      $error("window_length: expected %0d, got %0d", board.window_length, got);
      reg_errors++;
    end
  endtask

  task automatic set_window(logic [DATA_W-1:0] word);
    apb_write(REG_WINDOW_LENGTH, word);
    check_window_length();
    settings_used++;
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0: case ($urandom_range(3))
           0: return sample_t'(32767);
           1: return sample_t'(-32768);
           2: return sample_t'(0);
           default: return sample_t'(-1);
         endcase
      1, 2: return sample_t'(int'($urandom_range(200)) - 100);
      default: return sample_t'($urandom());
    endcase
  endfunction

  task automatic run_phase(logic [DATA_W-1:0] word, int count, bit restarts, bit last);
    drain();
    if (last) begin
      quiet = 1'b1;
    end else begin
      send_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(40, 5);
      recv_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(40, 5);
    end
    set_window(word);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain();
      send_sample(pick_sample(), restarts && $urandom_range(15) == 0);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 20;
    recv_idle_pct = 20;
    send_sample(sample_t'(32767), 1'b0);
    send_sample(sample_t'(32767), 1'b0);
    send_sample(sample_t'(-32768), 1'b0);
    send_sample(sample_t'(-32768), 1'b0);
    send_sample(sample_t'(-1), 1'b0);
    send_sample(sample_t'(1), 1'b0);
    send_sample(sample_t'(0), 1'b0);
    send_sample(sample_t'(32767), 1'b0);
    send_sample(sample_t'(-32768), 1'b0);
    send_sample(sample_t'(-32768), 1'b1);
    send_sample(sample_t'(-1), 1'b0);
    send_sample(sample_t'(32767), 1'b1);
    drain();
    set_window(DATA_W'(1));
    send_sample(sample_t'(-32768), 1'b0);
    send_sample(sample_t'(32767), 1'b0);
    send_sample(sample_t'(-7), 1'b1);
    drain();
    set_window(DATA_W'(0));
    send_sample(sample_t'(-32768), 1'b0);
    send_sample(sample_t'(32767), 1'b0);
    send_sample(sample_t'(-3), 1'b0);
    drain();
    set_window(DATA_W'(2047));
    send_sample(sample_t'(-32768), 1'b0);
    send_sample(sample_t'(-32768), 1'b0);
    send_sample(sample_t'(32767), 1'b0);
    drain();
    apb_write(REG_UNUSED, '1);
    check_window_length();
    send_sample(sample_t'(100), 1'b0);
    send_sample(sample_t'(-100), 1'b0);
    send_sample(sample_t'(5), 1'b0);

    run_phase(DATA_W'(3), 25, 1'b1, 1'b0);
    run_phase(DATA_W'(1024), 1030, 1'b0, 1'b0);
    run_phase(DATA_W'(0), 15, 1'b1, 1'b0);
    run_phase(DATA_W'(1025), 15, 1'b1, 1'b0);
    run_phase(32'hFFFF_F811, 20, 1'b1, 1'b0);
    run_phase(DATA_W'(1), 10, 1'b1, 1'b0);
    run_phase(DATA_W'($urandom_range(64, 2)), 35, 1'b1, 1'b1);

    drain();
    repeat (40) @(posedge clk);
    $display("Run covered %0d samples, %0d averages, %0d window reseeds", board.samples_seen,
             board.averages_seen, board.restarts);
    $display("over %0d window_length settings with random idling on both channels.",
             settings_used);
    if (board.errors == 0 && reg_errors == 0 && board.pending_averages.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[moving_average_filter_core.f]
rtl/mavg_pkg.sv
rtl/mavg_if.sv
rtl/mavg_front.sv
rtl/mavg_fifo.sv
rtl/mavg_back.sv
rtl/moving_average_filter_core.sv
bench/moving_average_filter_core_test.sv
